// ===== sv/mcr_pkg.sv =====
// Shared types and constants for the midpoint circle rasterizer.
// Used by the front end, the back end and the top level; no dependencies.
package mcr_pkg;

  // Input action codes carried on the slave tuser bit.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Eight mirrored points are emitted per octant step.
  typedef logic [2:0] point_idx_t;
  localparam point_idx_t FIRST_POINT = 3'd0;
  localparam point_idx_t LAST_POINT  = 3'd7;

  // Flags that travel with each job from the front end to the back end.
  typedef struct packed {
    logic idle;   // step arrived with no circle in progress
    logic fin;    // this step completes the circle
  } job_flags_t;

endpackage

// ===== sv/mcr_queue.sv =====
// Small register queue between the front end and the back end.
// Generic in width and depth; uses mcr_pkg for the job flag struct.
module mcr_queue #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcr_pkg::job_flags_t in_flags,
  input  logic [WIDTH-1:0]    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcr_pkg::job_flags_t out_flags,
  output logic [WIDTH-1:0]    out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mcr_pkg::job_flags_t flags_mem [DEPTH];
  logic [WIDTH-1:0]    data_mem  [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != CNT_FULL);
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_flags = flags_mem[rd_ptr];
  assign out_data  = data_mem[rd_ptr];

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      flags_mem[wr_ptr] <= in_flags;
      data_mem[wr_ptr]  <= in_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/mcr_front.sv =====
// Front end: accepts start and step beats and runs the midpoint walk.
// Pushes one job per step into the queue; uses mcr_pkg.
module mcr_front #(
  parameter int RADIUS_BITS = 8,
  parameter int COORD_BITS  = 10,
  parameter int JOB_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   action,
  input  logic [COORD_BITS-1:0]  center_x,
  input  logic [COORD_BITS-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0] radius,
  output logic                   job_valid,
  input  logic                   job_ready,
  output mcr_pkg::job_flags_t    job_flags,
  output logic [JOB_W-1:0]       job_data
);

  localparam int R = RADIUS_BITS;

  logic [COORD_BITS-1:0] centre_col;
  logic [COORD_BITS-1:0] centre_row;
  logic [R-1:0]          offset_major;
  logic [R:0]            offset_minor;
  logic signed [R+2:0]   decision_error;
  logic                  active;

  logic                  accept;
  logic [R:0]            minor_next;
  logic signed [R:0]     major_next;
  logic signed [R+2:0]   diff;
  logic signed [R+2:0]   error_next;
  logic                  fin;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  // Midpoint rule for the walk after this step.
  always_comb begin
    minor_next = offset_minor + 1'b1;
    major_next = $signed({1'b0, offset_major});
    diff       = '0;
    if (decision_error[R+2]) begin
      error_next = decision_error + $signed({1'b0, minor_next, 1'b1});
    end else begin
      major_next = $signed({1'b0, offset_major}) - $signed((R+1)'(1));
      diff       = $signed({2'b00, minor_next}) - $signed({{2{major_next[R]}}, major_next})
                   + $signed((R+3)'(1));
      error_next = decision_error + $signed({diff[R+1:0], 1'b0});
    end
    fin = $signed({1'b0, minor_next}) > $signed({major_next[R], major_next});
  end

  // Job handed to the back end: the current offsets before the update.
  assign job_valid      = accept && (action == mcr_pkg::ACT_STEP);
  assign job_flags.idle = !active;
  assign job_flags.fin  = fin;
  assign job_data       = {centre_col, centre_row, offset_major, offset_minor};

  // Walk state.
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_col     <= '0;
      centre_row     <= '0;
      offset_major   <= '0;
      offset_minor   <= '0;
      decision_error <= '0;
      active         <= 1'b0;
    end else if (accept) begin
      if (action == mcr_pkg::ACT_START) begin
        centre_col     <= center_x;
        centre_row     <= center_y;
        offset_major   <= radius;
        offset_minor   <= '0;
        decision_error <= $signed((R+3)'(1)) - $signed({3'b000, radius});
        active         <= 1'b1;
      end else if (active) begin
        offset_minor   <= minor_next;
        offset_major   <= major_next[R-1:0];
        decision_error <= error_next;
        if (fin) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/mcr_back.sv =====
// Back end: expands each queued job into its eight mirrored points.
// Drives the registered output beat; uses mcr_pkg.
module mcr_back #(
  parameter int RADIUS_BITS = 8,
  parameter int COORD_BITS  = 10,
  parameter int JOB_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 1,
  parameter int OUT_W       = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  mcr_pkg::job_flags_t job_flags,
  input  logic [JOB_W-1:0]    job_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_W-1:0]    m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);

  localparam int R  = RADIUS_BITS;
  localparam int C  = COORD_BITS;
  localparam int WW = (C + 1 > R + 2) ? C + 1 : R + 2;

  logic [C-1:0]        cx;
  logic [C-1:0]        cy;
  logic [R-1:0]        maj;
  logic [R:0]          mnr;
  logic [WW-1:0]       cx_w, cy_w, maj_w, mnr_w;
  logic [WW-1:0]       px, py;
  logic [OUT_W-1:0]    tdata_next;
  logic                load;
  logic                pop;
  mcr_pkg::point_idx_t idx;

  assign {cx, cy, maj, mnr} = job_data;
  assign cx_w  = {{(WW-C){cx[C-1]}}, cx};
  assign cy_w  = {{(WW-C){cy[C-1]}}, cy};
  assign maj_w = {{(WW-R){1'b0}}, maj};
  assign mnr_w = {{(WW-R-1){1'b0}}, mnr};

  assign load      = job_valid && (!m_tvalid || m_tready);
  assign pop       = load && (job_flags.idle || idx == mcr_pkg::LAST_POINT);
  assign job_ready = pop;

  // Select the mirrored point for the current index.
  always_comb begin
    case (idx)
      3'd0:    begin px = cx_w + maj_w; py = cy_w + mnr_w; end
      3'd1:    begin px = cx_w + mnr_w; py = cy_w + maj_w; end
      3'd2:    begin px = cx_w - maj_w; py = cy_w + mnr_w; end
      3'd3:    begin px = cx_w - mnr_w; py = cy_w + maj_w; end
      3'd4:    begin px = cx_w - maj_w; py = cy_w - mnr_w; end
      3'd5:    begin px = cx_w - mnr_w; py = cy_w - maj_w; end
      3'd6:    begin px = cx_w + maj_w; py = cy_w - mnr_w; end
      default: begin px = cx_w + mnr_w; py = cy_w - maj_w; end
    endcase
    if (job_flags.idle) begin
      px = '0;
      py = '0;
    end
    tdata_next = '0;
    tdata_next[2*C+1:0] = {py[C:0], px[C:0]};
  end

  // Point index within the current job.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= mcr_pkg::FIRST_POINT;
    end else if (pop) begin
      idx <= mcr_pkg::FIRST_POINT;
    end else if (load) begin
      idx <= idx + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= tdata_next;
      m_tlast <= pop;
      m_tuser <= job_flags.fin || job_flags.idle;
    end
  end

  // A job in progress keeps its queue entry until its last point.
  a_job_held: assert property (@(posedge clk) disable iff (rst)
    (idx != mcr_pkg::FIRST_POINT) |-> job_valid)
    else $error("point index advanced without a queued job");

  // An idle step is always a single point.
  a_idle_single: assert property (@(posedge clk) disable iff (rst)
    (load && job_flags.idle) |-> (idx == mcr_pkg::FIRST_POINT))
    else $error("idle step reached inside a point run");

  // Popping a job restarts the index.
  a_pop_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == mcr_pkg::FIRST_POINT))
    else $error("point index not restarted after job");

endmodule

// ===== sv/midpoint_circle_rasterizer_top.sv =====
// Midpoint circle point generator: a start beat loads the centre and radius, and
// each step beat yields the eight mirrored points of one octant step. A start beat
// yields nothing; a step yields eight output beats at one per cycle while tready
// stays high, a rate set by the single output register of the back end. A step with
// no circle in progress yields one beat with zero coordinates, tlast and tuser set.
// A two-entry job queue lets the front end take the next beats while points of
// earlier steps are still going out.
// Top level: instantiates mcr_front, mcr_queue and mcr_back; uses mcr_pkg.
module midpoint_circle_rasterizer_top #(
  parameter int RADIUS_BITS = 8,
  parameter int COORD_BITS  = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // tdata, from bit 0: center_x, center_y, radius, zero fill
  input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_tdata,
  // tuser: action (start or step)
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // tdata, from bit 0: point_x, point_y, zero fill
  output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_tdata,
  // tlast: last_point
  output logic m_tlast,
  // tuser: finished, or step with no circle in progress
  output logic m_tuser
);

  localparam int C     = COORD_BITS;
  localparam int R     = RADIUS_BITS;
  localparam int JOB_W = 2 * C + 2 * R + 1;
  localparam int OUT_W = ((2 * C + 2 + 7) / 8) * 8;

  logic                f_valid, f_ready;
  mcr_pkg::job_flags_t f_flags;
  logic [JOB_W-1:0]    f_data;
  logic                q_valid, q_ready;
  mcr_pkg::job_flags_t q_flags;
  logic [JOB_W-1:0]    q_data;

  mcr_front #(
    .RADIUS_BITS(R),
    .COORD_BITS (C),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .action   (s_tuser),
    .center_x (s_tdata[C-1:0]),
    .center_y (s_tdata[2*C-1:C]),
    .radius   (s_tdata[2*C+R-1:2*C]),
    .job_valid(f_valid),
    .job_ready(f_ready),
    .job_flags(f_flags),
    .job_data (f_data)
  );

  mcr_queue #(
    .WIDTH(JOB_W),
    .DEPTH(2)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_flags (f_flags),
    .in_data  (f_data),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_flags(q_flags),
    .out_data (q_data)
  );

  mcr_back #(
    .RADIUS_BITS(R),
    .COORD_BITS (C),
    .JOB_W      (JOB_W),
    .OUT_W      (OUT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(q_valid),
    .job_ready(q_ready),
    .job_flags(q_flags),
    .job_data (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
